[hdl/lfu_pkg.sv]
`timescale 1ns / 1ps
// Package for the LFU cache table: transfer payload types and sequencer codes.
// No dependencies; used by lfu_cache_table.
package lfu_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 6;

   typedef struct packed {
      logic                          command;
      logic signed [KEY_BITS-1:0]    key;
      logic signed [VALUE_BITS-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic signed [VALUE_BITS-1:0]  read_value;
      logic                          evicted;
      logic signed [KEY_BITS-1:0]    evicted_key;
   } rsp_type;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_HIT,
      MODE_EVICT,
      MODE_FILL
   } mode_type;

endpackage

[hdl/lfu_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lfu_cache_table.sv]
`timescale 1ns / 1ps
// Top level of the LFU cache table: sequencer, scan and update logic, entry RAM.
// Depends on lfu_pkg and lfu_ram.
//
// Usage: a request (get or put of a key) is a transfer on req_valid/req_ready with
// the payload req_data. Every request gives exactly one response on rsp_valid/
// rsp_ready with rsp_data: found, the old value on a hit, and the evicted key when
// a put had to remove an entry. The capacity register is written through
// csr_write_enable/csr_write_data; the user must write it only while the block is
// idle, as the block itself does not enforce this; it takes effect at once. Each
// request takes a scan pass over all MAX_ENTRIES entries of the entry RAM, one
// entry per cycle, and for hits and inserts an update pass of the same length that
// rewrites ranks and counts. The RAM read port sets the pace. A new request is
// taken while a response still waits for rsp_ready; the block then holds its next
// response until the receiver takes the old one. Reset clears all valid bits at
// once and sets the capacity to 32; no clearing pass is needed.
module lfu_cache_table #(
   parameter int MAX_ENTRIES = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lfu_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lfu_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_enable,
   input  logic [lfu_pkg::CAP_BITS-1:0]   csr_write_data
);

   localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RB   = IW;
   localparam int FW   = $clog2(MAX_ENTRIES + 1);
   localparam int KB   = lfu_pkg::KEY_BITS;
   localparam int VB   = lfu_pkg::VALUE_BITS;
   localparam int W    = KB + VB + COUNT_BITS + RB;
   localparam int CMPW = 9;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   lfu_pkg::state_type state_ff, state_in;
   lfu_pkg::mode_type  mode_ff, mode_in;

   logic [lfu_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic [MAX_ENTRIES-1:0]       valid_ff, valid_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic                         issue_done_ff, issue_done_in;
   logic                         pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]                pipe_idx_ff, pipe_idx_in;

   logic                         cmd_ff, cmd_in;
   logic [KB-1:0]                key_ff, key_in;
   logic [VB-1:0]                val_ff, val_in;

   logic                         hit_ff, hit_in;
   logic [IW-1:0]                hit_idx_ff, hit_idx_in;
   logic [VB-1:0]                hit_val_ff, hit_val_in;
   logic [RB-1:0]                hit_rank_ff, hit_rank_in;
   logic                         vic_ff, vic_in;
   logic [IW-1:0]                vic_idx_ff, vic_idx_in;
   logic [KB-1:0]                vic_key_ff, vic_key_in;
   logic [COUNT_BITS-1:0]        vic_cnt_ff, vic_cnt_in;
   logic [RB-1:0]                vic_rank_ff, vic_rank_in;
   logic                         free_ff, free_in;
   logic [IW-1:0]                free_idx_ff, free_idx_in;
   logic [FW-1:0]                fill_ff, fill_in;

   logic [IW-1:0]                target_ff, target_in;
   logic [RB-1:0]                ref_rank_ff, ref_rank_in;
   lfu_pkg::rsp_type             res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lfu_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         ram_we;
   logic [IW-1:0]                ram_rd_addr;
   logic [W-1:0]                 ram_wr_data;
   logic [W-1:0]                 ram_rd_data;

   logic [KB-1:0]                d_key;
   logic [VB-1:0]                d_val;
   logic [COUNT_BITS-1:0]        d_cnt;
   logic [RB-1:0]                d_rank;
   logic                         d_valid;
   logic [CMPW-1:0]              cap_eff;
   logic [CMPW-1:0]              fill_ext;

   lfu_ram #(
      .WIDTH (W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pipe_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign d_key   = ram_rd_data[W-1 -: KB];
   assign d_val   = ram_rd_data[W-KB-1 -: VB];
   assign d_cnt   = ram_rd_data[COUNT_BITS+RB-1 : RB];
   assign d_rank  = ram_rd_data[RB-1:0];
   assign d_valid = valid_ff[pipe_idx_ff];

   assign fill_ext = CMPW'(fill_ff);
   assign cap_eff  = (CMPW'(cap_ff) > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES)
                                                          : CMPW'(cap_ff);

   assign req_ready = (state_ff == lfu_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lfu_pkg::ST_IDLE;
         cap_ff        <= lfu_pkg::CAP_BITS'(32);
         valid_ff      <= '0;
         issue_done_ff <= 1'b1;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= lfu_pkg::MODE_NONE;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         valid_ff      <= valid_in;
         issue_done_ff <= issue_done_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pipe_idx_ff <= pipe_idx_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      hit_rank_ff <= hit_rank_in;
      vic_ff      <= vic_in;
      vic_idx_ff  <= vic_idx_in;
      vic_key_ff  <= vic_key_in;
      vic_cnt_ff  <= vic_cnt_in;
      vic_rank_ff <= vic_rank_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      fill_ff     <= fill_in;
      target_ff   <= target_in;
      ref_rank_ff <= ref_rank_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cap_in        = csr_write_enable ? csr_write_data : cap_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      hit_rank_in   = hit_rank_ff;
      vic_in        = vic_ff;
      vic_idx_in    = vic_idx_ff;
      vic_key_in    = vic_key_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_rank_in   = vic_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      fill_in       = fill_ff;
      target_in     = target_ff;
      ref_rank_in   = ref_rank_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_data   = ram_rd_data;

      if ((state_ff == lfu_pkg::ST_SCAN || state_ff == lfu_pkg::ST_UPDATE)
          && !issue_done_ff) begin
         pipe_vld_in = 1'b1;
         idx_in      = idx_ff + IW'(1);
         if (idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end
      end

      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_data.command;
               key_in        = req_data.key;
               val_in        = req_data.value;
               hit_in        = 1'b0;
               vic_in        = 1'b0;
               free_in       = 1'b0;
               fill_in       = '0;
               idx_in        = '0;
               issue_done_in = 1'b0;
               state_in      = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (pipe_vld_ff) begin
               if (d_valid) begin
                  fill_in = fill_ff + FW'(1);
                  if (d_key == key_ff) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = pipe_idx_ff;
                     hit_val_in  = d_val;
                     hit_rank_in = d_rank;
                  end
                  if (!vic_ff || d_cnt < vic_cnt_ff
                      || (d_cnt == vic_cnt_ff && d_rank > vic_rank_ff)) begin
                     vic_in      = 1'b1;
                     vic_idx_in  = pipe_idx_ff;
                     vic_key_in  = d_key;
                     vic_cnt_in  = d_cnt;
                     vic_rank_in = d_rank;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = lfu_pkg::ST_DECIDE;
               end
            end
         end
         lfu_pkg::ST_DECIDE: begin
            res_in        = '0;
            idx_in        = '0;
            issue_done_in = 1'b0;
            state_in      = lfu_pkg::ST_UPDATE;
            if (hit_ff) begin
               mode_in            = lfu_pkg::MODE_HIT;
               target_in          = hit_idx_ff;
               ref_rank_in        = hit_rank_ff;
               res_in.found       = 1'b1;
               res_in.read_value  = hit_val_ff;
            end else if (cmd_ff == lfu_pkg::CMD_GET || cap_eff == '0) begin
               mode_in       = lfu_pkg::MODE_NONE;
               issue_done_in = 1'b1;
               state_in      = lfu_pkg::ST_DONE;
            end else if (fill_ext >= cap_eff && vic_ff) begin
               mode_in            = lfu_pkg::MODE_EVICT;
               target_in          = vic_idx_ff;
               ref_rank_in        = vic_rank_ff;
               res_in.evicted     = 1'b1;
               res_in.evicted_key = vic_key_ff;
            end else begin
               mode_in   = lfu_pkg::MODE_FILL;
               target_in = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
            end
         end
         lfu_pkg::ST_UPDATE: begin
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == target_ff) begin
                  ram_we = 1'b1;
                  if (mode_ff == lfu_pkg::MODE_HIT) begin
                     ram_wr_data = {d_key,
                                    (cmd_ff == lfu_pkg::CMD_PUT) ? val_ff : d_val,
                                    (d_cnt == COUNT_MAX) ? d_cnt
                                                         : d_cnt + COUNT_BITS'(1),
                                    RB'(0)};
                  end else begin
                     ram_wr_data = {key_ff, val_ff, COUNT_BITS'(1), RB'(0)};
                  end
               end else if (d_valid) begin
                  ram_we = 1'b1;
                  unique case (mode_ff)
                     lfu_pkg::MODE_HIT: begin
                        if (d_rank < ref_rank_ff) begin
                           ram_wr_data[RB-1:0] = d_rank + RB'(1);
                        end
                     end
                     lfu_pkg::MODE_EVICT: begin
                        if (d_rank <= ref_rank_ff) begin
                           ram_wr_data[RB-1:0] = d_rank + RB'(1);
                        end
                     end
                     lfu_pkg::MODE_FILL: begin
                        ram_wr_data[RB-1:0] = d_rank + RB'(1);
                     end
                     default: begin
                        ram_we = 1'b0;
                     end
                  endcase
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = lfu_pkg::ST_DONE;
               end
            end
         end
         lfu_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   a_pipe_only_in_pass: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> (state_ff == lfu_pkg::ST_SCAN || state_ff == lfu_pkg::ST_UPDATE))
      else $error("RAM read data returned outside a scan or update pass");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfu_pkg::ST_DECIDE |-> fill_ff == FW'($countones(valid_ff)))
      else $error("Scan fill count disagrees with the valid bits");

   a_target_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfu_pkg::ST_UPDATE |-> valid_ff[target_ff])
      else $error("Update pass targets an entry that is not valid");

   a_done_after_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfu_pkg::ST_UPDATE && pipe_vld_ff && pipe_idx_ff == LAST_IDX)
      |=> state_ff == lfu_pkg::ST_DONE)
      else $error("Update pass did not end after the last entry");

endmodule
